@@ rtl/ped_pkg.sv @@
// Shared types and character constants for the percent escape decoder.
// Used by the front, queue and back modules; depends on nothing.
package ped_pkg;

	localparam logic [7:0] CHAR_PCT  = 8'h25;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_LA   = 8'h61;
	localparam logic [7:0] CHAR_LF   = 8'h66;
	localparam logic [7:0] CHAR_UA   = 8'h41;
	localparam logic [7:0] CHAR_UF   = 8'h46;

	// One queued command: the results that one input item causes.
	typedef struct packed {
		logic [7:0] byte0;
		logic       valid0;
		logic [7:0] byte1;
		logic       two;
		logic       str_end;
	} cmd_t;

endpackage

@@ rtl/ped_enc_if.sv @@
// Handshake channel for escaped input bytes.
// Depends on nothing.
interface ped_enc_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ rtl/ped_dec_if.sv @@
// Handshake channel for decoded result items.
// Depends on nothing.
interface ped_dec_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       run_last;
	logic       string_end;

	modport source (output valid, output out_byte, output out_valid, output run_last,
		output string_end, input ready);
	modport sink (input valid, input out_byte, input out_valid, input run_last,
		input string_end, output ready);
endinterface

@@ rtl/ped_front.sv @@
// Front part: accepts input bytes, runs the decode state machine and
// builds at most one queue command per item. Depends on ped_pkg and ped_enc_if.
module ped_front (
	input  logic            clk,
	input  logic            arst_n,
	ped_enc_if.sink         enc,
	input  logic            q_ready,
	output logic            push,
	output ped_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {PH_NORMAL, PH_PCT, PH_DIGIT, PH_DONE} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;
	logic       accept;
	logic       slot0, slot1;
	logic       b_hex;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= ped_pkg::CHAR_ZERO && c <= ped_pkg::CHAR_NINE) ||
			(c >= ped_pkg::CHAR_LA && c <= ped_pkg::CHAR_LF) ||
			(c >= ped_pkg::CHAR_UA && c <= ped_pkg::CHAR_UF);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		if (c <= ped_pkg::CHAR_NINE) begin
			return c[3:0];
		end
		return c[3:0] + 4'd9;
	endfunction

	assign enc.ready = q_ready;
	assign accept    = enc.valid & q_ready;
	assign b_hex     = is_hex(enc.in_byte);

	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		slot0   = 1'b0;
		slot1   = 1'b0;
		cmd     = '0;
		case (phase_q)
			PH_NORMAL: begin
				if (enc.in_byte == 8'd0) begin
					phase_d = PH_DONE;
				end else if (enc.in_byte == ped_pkg::CHAR_PCT) begin
					phase_d = PH_PCT;
				end else begin
					cmd.byte0 = enc.in_byte;
					slot0     = 1'b1;
				end
			end
			PH_PCT: begin
				if (enc.in_byte == 8'd0) begin
					phase_d = PH_DONE;
				end else if (b_hex) begin
					held_d  = enc.in_byte;
					phase_d = PH_DIGIT;
				end else if (enc.in_byte != ped_pkg::CHAR_PCT) begin
					cmd.byte0 = enc.in_byte;
					slot0     = 1'b1;
					phase_d   = PH_NORMAL;
				end
			end
			PH_DIGIT: begin
				cmd.byte0 = held_q;
				slot0     = 1'b1;
				if (b_hex) begin
					cmd.byte0 = {hex_val(held_q), hex_val(enc.in_byte)};
					phase_d   = PH_NORMAL;
					held_d    = 8'd0;
				end else if (enc.in_byte == 8'd0) begin
					phase_d = PH_DONE;
				end else if (enc.in_byte == ped_pkg::CHAR_PCT) begin
					phase_d = PH_PCT;
				end else begin
					cmd.byte1 = enc.in_byte;
					slot1     = 1'b1;
					phase_d   = PH_NORMAL;
				end
			end
			default: begin
			end
		endcase
		cmd.valid0 = slot0;
		if (enc.in_last) begin
			// Only the step from a pending percent to a held digit leaves a
			// digit here, and that step has emitted nothing yet.
			if (phase_d == PH_DIGIT) begin
				cmd.byte0  = held_d;
				cmd.valid0 = 1'b1;
			end
			cmd.str_end = 1'b1;
			phase_d     = PH_NORMAL;
			held_d      = 8'd0;
		end
		cmd.two = slot1;
		push    = accept & (slot0 | enc.in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
			held_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_held_is_hex: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIGIT |-> is_hex(held_q))
		else $error("Held digit is not a hex character.");
	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && enc.in_last |-> push && cmd.str_end)
		else $error("Last item did not produce an end command.");
`endif

endmodule

@@ rtl/ped_queue.sv @@
// Short command queue between the front and back parts.
// Depends on ped_pkg.
module ped_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ped_pkg::cmd_t   push_data,
	output logic            ready,
	input  logic            pop,
	output logic            head_vld,
	output ped_pkg::cmd_t   head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ped_pkg::cmd_t      entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign ready    = count_q != CNT_W'(DEPTH);
	assign head_vld = count_q != '0;
	assign head     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("Command queue overflow.");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_vld)
		else $error("Pop from an empty command queue.");
`endif

endmodule

@@ rtl/ped_back.sv @@
// Back part: takes commands from the queue and sends their results one per
// transfer through an output register. Depends on ped_pkg and ped_dec_if.
module ped_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_vld,
	input  ped_pkg::cmd_t   head,
	output logic            pop,
	ped_dec_if.source       dec
);

	logic       sel_q;
	logic       ovld_q;
	logic [7:0] obyte_q;
	logic       ovalid_q, orun_q, oend_q;
	logic       load;
	logic       final_res;

	assign load      = head_vld & (~ovld_q | dec.ready);
	assign final_res = ~head.two | sel_q;
	assign pop       = load & final_res;

	assign dec.valid      = ovld_q;
	assign dec.out_byte   = obyte_q;
	assign dec.out_valid  = ovalid_q;
	assign dec.run_last   = orun_q;
	assign dec.string_end = oend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q  <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (load) begin
				ovld_q <= 1'b1;
				sel_q  <= ~final_res;
			end else if (dec.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obyte_q  <= sel_q ? head.byte1 : head.byte0;
			ovalid_q <= sel_q | head.valid0;
			orun_q   <= final_res;
			oend_q   <= final_res & head.str_end;
		end
	end

`ifndef NO_ASSERTIONS
	a_sel_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> head_vld && head.two)
		else $error("Second result selected without a two-result command.");
	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		dec.valid && dec.string_end |-> dec.run_last)
		else $error("String end on a result that is not the last of its item.");
`endif

endmodule

@@ rtl/percent_escape_decoder.sv @@
// Top level of the percent escape decoder: front, command queue and back.
// Depends on ped_pkg, ped_enc_if, ped_dec_if, ped_front, ped_queue, ped_back.
//
//   Port  Direction  Payload                                   Transfer
//   enc   sink       in_byte, in_last                          valid & ready
//   dec   source     out_byte, out_valid, run_last, string_end valid & ready
//
// One input item is taken per cycle while the command queue has room.
// Results leave one per cycle while dec.ready is high; an item with two results
// takes two output transfers, so the output register sets the long-run rate.
// A result passes through a queue entry and then the output register.
// Reset clears the decode phase, the queue pointers and the output valid.
module percent_escape_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	ped_enc_if.sink    enc,
	ped_dec_if.source  dec
);

	ped_pkg::cmd_t push_cmd, head_cmd;
	logic          push, q_ready, pop, head_vld;

	ped_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.enc     (enc),
		.q_ready (q_ready),
		.push    (push),
		.cmd     (push_cmd)
	);

	ped_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.ready     (q_ready),
		.pop       (pop),
		.head_vld  (head_vld),
		.head      (head_cmd)
	);

	ped_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (head_vld),
		.head     (head_cmd),
		.pop      (pop),
		.dec      (dec)
	);

endmodule
